### rtl/u1_metropolis_link_update_defines.svh
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - assertion macros
// Shared concurrent assertion helpers, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef U1_METROPOLIS_LINK_UPDATE_DEFINES_SVH
`define U1_METROPOLIS_LINK_UPDATE_DEFINES_SVH

// same-cycle implication
`define U1ML_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U1ML_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/u1ml_pkg.sv
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - package
// Widths, constants, tables and pipeline stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package u1ml_pkg;

    localparam int LINK_W     = 16;
    localparam int STAPLE_W   = 18;
    localparam int RAND_W     = 16;
    localparam int BETA_W     = 16;
    localparam int SCALE_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_DIMS_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;

    localparam logic [BETA_W-1:0]  BETA_RST  = 16'd256;
    localparam logic [SCALE_W-1:0] SCALE_RST = 15'd4096;

    // angle path
    localparam int TPROD_W      = SCALE_W + 1 + RAND_W + 2;
    localparam int CORDIC_ITERS = 16;
    localparam int XY_W         = 33;
    localparam int Z_W          = 21;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [Z_W-1:0]  PI_Q16      = 21'sd205887;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q16 = 21'sd102944;

    localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_ITERS] = '{
        21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
        21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32,
        21'sd16, 21'sd8, 21'sd4, 21'sd2
    };

    // rotation and normalization
    localparam int PROD_W = LINK_W + XY_W;
    localparam int W_W    = 28;
    localparam int SQ_W   = 54;
    localparam int RT_W   = 27;
    localparam int QB     = 15;
    localparam int DR_W   = RT_W + QB;
    localparam logic [QB-1:0] UNIT_Q14 = 15'd16384;

    // action and acceptance
    localparam int SPROD_W = LINK_W + STAPLE_W;
    localparam int ACT_W   = 36;
    localparam int DELTA_W = ACT_W + BETA_W + 1;
    localparam int X_W     = DELTA_W - 20;
    localparam int Y_W     = 20;
    localparam int N_W     = 5;
    localparam int RCP_W   = 21;
    localparam int LN2_Q16 = 45426;
    localparam logic [RCP_W-1:0] LN2_RECIP = RCP_W'((64'd1 << 36) / LN2_Q16 + 64'd1);
    localparam logic signed [X_W-1:0] EXP_FLOOR = -33'sd1048576;

    localparam int R30_W = 30;
    localparam int T_W   = 31;
    localparam int HP_W  = R30_W + T_W;
    localparam int MF_W  = 33;
    localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam int HORNER_STEPS = 7;
    localparam int HORNER_K [HORNER_STEPS] = '{7, 6, 5, 4, 3, 2, 1};
    localparam logic [MF_W-1:0] HORNER_MF [HORNER_STEPS] = '{
        MF_W'((64'd1 << 32) / 7), MF_W'((64'd1 << 32) / 6), MF_W'((64'd1 << 32) / 5),
        MF_W'((64'd1 << 32) / 4), MF_W'((64'd1 << 32) / 3), MF_W'((64'd1 << 32) / 2),
        MF_W'((64'd1 << 32) / 1)
    };

    localparam int NSTAGE = 2 + CORDIC_ITERS + 4 + RT_W + 1 + QB + 7 + 3 * HORNER_STEPS;

    typedef struct packed {
        logic signed [LINK_W-1:0]   ur;
        logic signed [LINK_W-1:0]   ui;
        logic signed [STAPLE_W-1:0] sr;
        logic signed [STAPLE_W-1:0] si;
        logic [RAND_W-1:0]          rb;
    } carry_t;

    typedef struct packed {
        carry_t                    base;
        logic signed [TPROD_W-1:0] prod;
    } s0_t;

    typedef struct packed {
        carry_t                 base;
        logic                   flip;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        carry_t                    base;
        logic signed [PROD_W-1:0]  p_rc;
        logic signed [PROD_W-1:0]  p_is;
        logic signed [PROD_W-1:0]  p_rs;
        logic signed [PROD_W-1:0]  p_ic;
        logic signed [SPROD_W-1:0] o_rr;
        logic signed [SPROD_W-1:0] o_ii;
    } m1_t;

    typedef struct packed {
        carry_t                  base;
        logic signed [W_W-1:0]   wr;
        logic signed [W_W-1:0]   wi;
        logic signed [ACT_W-1:0] act_old;
    } m2_t;

    typedef struct packed {
        carry_t                  base;
        logic signed [W_W-1:0]   wr;
        logic signed [W_W-1:0]   wi;
        logic signed [ACT_W-1:0] act_old;
        logic [SQ_W-1:0]         sq_r;
        logic [SQ_W-1:0]         sq_i;
    } m3_t;

    typedef struct packed {
        carry_t                  base;
        logic signed [W_W-1:0]   wr;
        logic signed [W_W-1:0]   wi;
        logic signed [ACT_W-1:0] act_old;
        logic [SQ_W-1:0]         rem;
        logic [RT_W-1:0]         root;
    } sq_t;

    typedef struct packed {
        carry_t                  base;
        logic signed [ACT_W-1:0] act_old;
        logic                    neg_r;
        logic                    neg_i;
        logic                    zero;
        logic [RT_W-1:0]         mag;
        logic [DR_W-1:0]         rem_r;
        logic [DR_W-1:0]         rem_i;
        logic [QB-1:0]           q_r;
        logic [QB-1:0]           q_i;
    } dv_t;

    typedef struct packed {
        carry_t                   base;
        logic signed [ACT_W-1:0]  act_old;
        logic                     zero;
        logic signed [LINK_W-1:0] pr;
        logic signed [LINK_W-1:0] pi;
    } f0_t;

    typedef struct packed {
        logic signed [LINK_W-1:0] ur;
        logic signed [LINK_W-1:0] ui;
        logic [RAND_W-1:0]        rb;
        logic signed [LINK_W-1:0] pr;
        logic signed [LINK_W-1:0] pi;
        logic                     zero;
    } tail_t;

    typedef struct packed {
        tail_t                     tl;
        logic signed [ACT_W-1:0]   act_old;
        logic signed [SPROD_W-1:0] n_rr;
        logic signed [SPROD_W-1:0] n_ii;
    } a1_t;

    typedef struct packed {
        tail_t                   tl;
        logic signed [ACT_W-1:0] d;
    } a2_t;

    typedef struct packed {
        tail_t                     tl;
        logic signed [DELTA_W-1:0] delta;
    } a3_t;

    typedef struct packed {
        tail_t                tl;
        logic                 pos;
        logic                 sat;
        logic [Y_W-1:0]       y;
        logic [Y_W+RCP_W-1:0] yp;
    } e_t;

    typedef struct packed {
        tail_t            tl;
        logic             pos;
        logic             sat;
        logic [N_W-1:0]   n;
        logic [R30_W-1:0] r30;
        logic [T_W-1:0]   t;
        logic [HP_W-1:0]  hp;
        logic [R30_W-1:0] v;
        logic [R30_W-1:0] qe;
    } hn_t;

    typedef struct packed {
        logic signed [LINK_W-1:0] new_re;
        logic signed [LINK_W-1:0] new_im;
        logic                     accepted;
    } res_t;

endpackage

`default_nettype wire

### rtl/u1ml_if.sv
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - channel interfaces
// Valid/ready channels for link items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface u1ml_in_if
    import u1ml_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [LINK_W-1:0]   link_re;
    logic signed [LINK_W-1:0]   link_im;
    logic signed [STAPLE_W-1:0] staple_re;
    logic signed [STAPLE_W-1:0] staple_im;
    logic [RAND_W-1:0]          rand_angle;
    logic [RAND_W-1:0]          rand_accept;

    modport source (output valid, link_re, link_im, staple_re, staple_im,
                    rand_angle, rand_accept, input ready);
    modport sink   (input valid, link_re, link_im, staple_re, staple_im,
                    rand_angle, rand_accept, output ready);
endinterface

interface u1ml_out_if
    import u1ml_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [LINK_W-1:0] new_re;
    logic signed [LINK_W-1:0] new_im;
    logic                     accepted;

    modport source (output valid, new_re, new_im, accepted, input ready);
    modport sink   (input valid, new_re, new_im, accepted, output ready);
endinterface

interface u1ml_cfg_if
    import u1ml_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/u1_metropolis_link_update.sv
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - top level
// Proposes a rotated link, renormalizes it and runs the Metropolis test.
// ----------------------------------------------------------------------------
// channel   | dir | payload
// cfg       | in  | index, data (coupling_beta, step_scale)
// link_in   | in  | link_re/im, staple_re/im, rand_angle, rand_accept
// link_out  | out | new_re, new_im, accepted
//
// One transaction per cycle enters the pipeline while the second output buffer entry is free.
// Depth is set by the 16 CORDIC steps, the 27-step square root, the 15-step
// dividers and the 7-term exp series (three stages per term).
// Reset clears the valid bits and the output buffer; the registers reload defaults.
// The whole pipeline holds while the second output buffer entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module u1_metropolis_link_update
    import u1ml_pkg::*;
#(
    parameter int NUM_DIMS = NUM_DIMS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u1ml_cfg_if.sink    cfg,
    u1ml_in_if.sink     link_in,
    u1ml_out_if.source  link_out
);

    localparam logic signed [STAPLE_W+1:0] LIM = (STAPLE_W+2)'(2 * (NUM_DIMS - 1) * 16384);
    localparam int HN_N = 3 * HORNER_STEPS;

    logic [BETA_W-1:0]  beta_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic              en;
    logic              in_fire;
    logic [NSTAGE-1:0] vld_reg;
    logic              push;
    logic              pop;
    logic              out_in_range;

    s0_t     s0_reg, s0_next;
    cordic_t cr_reg  [CORDIC_ITERS+1];
    cordic_t cr_next [CORDIC_ITERS+1];
    m1_t     m1_reg, m1_next;
    m2_t     m2_reg, m2_next;
    m3_t     m3_reg, m3_next;
    sq_t     sq_reg  [RT_W+1];
    sq_t     sq_next [RT_W+1];
    dv_t     dv_reg  [QB+1];
    dv_t     dv_next [QB+1];
    f0_t     f0_reg, f0_next;
    a1_t     a1_reg, a1_next;
    a2_t     a2_reg, a2_next;
    a3_t     a3_reg, a3_next;
    e_t      e0_reg, e0_next;
    e_t      e1_reg, e1_next;
    hn_t     hn_reg  [HN_N+1];
    hn_t     hn_next [HN_N+1];
    res_t    res;
    res_t    q0_reg, q1_reg;
    logic    q0_valid_reg, q1_valid_reg;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= BETA_RST;
            scale_reg <= SCALE_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_BETA)
            begin
                beta_reg <= cfg.data;
            end
            else if (cfg.index == REG_SCALE)
            begin
                scale_reg <= cfg.data[SCALE_W-1:0];
            end
        end
    end

    // flow control
    assign en            = ~q1_valid_reg;
    assign link_in.ready = en;
    assign in_fire       = link_in.valid & en;
    assign push          = en & vld_reg[NSTAGE-1];
    assign pop           = q0_valid_reg & link_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_fire};
        end
    end

    // staple clamp and proposal angle product
    always_comb
    begin
        logic signed [STAPLE_W+1:0] sr_e;
        logic signed [STAPLE_W+1:0] si_e;
        logic signed [RAND_W+1:0]   ang;
        sr_e = (STAPLE_W+2)'(link_in.staple_re);
        si_e = (STAPLE_W+2)'(link_in.staple_im);
        ang  = $signed({1'b0, link_in.rand_angle, 1'b0}) - (RAND_W+2)'(65536);
        s0_next.base.ur = link_in.link_re;
        s0_next.base.ui = link_in.link_im;
        s0_next.base.rb = link_in.rand_accept;
        s0_next.base.sr = link_in.staple_re;
        s0_next.base.si = link_in.staple_im;
        if (sr_e > LIM)
        begin
            s0_next.base.sr = LIM[STAPLE_W-1:0];
        end
        else if (sr_e < -LIM)
        begin
            s0_next.base.sr = STAPLE_W'(-LIM);
        end
        if (si_e > LIM)
        begin
            s0_next.base.si = LIM[STAPLE_W-1:0];
        end
        else if (si_e < -LIM)
        begin
            s0_next.base.si = STAPLE_W'(-LIM);
        end
        s0_next.prod = $signed({1'b0, scale_reg}) * ang;
    end

    // angle reduction into the CORDIC entry, then the rotation steps
    always_comb
    begin
        logic signed [Z_W-1:0] th;
        th = Z_W'(s0_reg.prod >>> 13);
        cr_next[0].base = s0_reg.base;
        cr_next[0].x    = CORDIC_GAIN;
        cr_next[0].y    = '0;
        cr_next[0].flip = 1'b0;
        cr_next[0].z    = th;
        if (th > HALF_PI_Q16)
        begin
            cr_next[0].z    = th - PI_Q16;
            cr_next[0].flip = 1'b1;
        end
        else if (th < -HALF_PI_Q16)
        begin
            cr_next[0].z    = th + PI_Q16;
            cr_next[0].flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            cr_next[i+1] = cr_reg[i];
            if (cr_reg[i].z >= 0)
            begin
                cr_next[i+1].x = cr_reg[i].x - (cr_reg[i].y >>> i);
                cr_next[i+1].y = cr_reg[i].y + (cr_reg[i].x >>> i);
                cr_next[i+1].z = cr_reg[i].z - ATAN_Q16[i];
            end
            else
            begin
                cr_next[i+1].x = cr_reg[i].x + (cr_reg[i].y >>> i);
                cr_next[i+1].y = cr_reg[i].y - (cr_reg[i].x >>> i);
                cr_next[i+1].z = cr_reg[i].z + ATAN_Q16[i];
            end
        end
    end

    // rotate the link and form the old action terms
    always_comb
    begin
        logic signed [XY_W-1:0] c;
        logic signed [XY_W-1:0] s;
        c = cr_reg[CORDIC_ITERS].flip ? -cr_reg[CORDIC_ITERS].x : cr_reg[CORDIC_ITERS].x;
        s = cr_reg[CORDIC_ITERS].flip ? -cr_reg[CORDIC_ITERS].y : cr_reg[CORDIC_ITERS].y;
        m1_next.base = cr_reg[CORDIC_ITERS].base;
        m1_next.p_rc = m1_next.base.ur * c;
        m1_next.p_is = m1_next.base.ui * s;
        m1_next.p_rs = m1_next.base.ur * s;
        m1_next.p_ic = m1_next.base.ui * c;
        m1_next.o_rr = m1_next.base.ur * m1_next.base.sr;
        m1_next.o_ii = m1_next.base.ui * m1_next.base.si;
    end

    always_comb
    begin
        logic signed [PROD_W:0] sum_r;
        logic signed [PROD_W:0] sum_i;
        sum_r = (PROD_W+1)'(m1_reg.p_rc) - (PROD_W+1)'(m1_reg.p_is);
        sum_i = (PROD_W+1)'(m1_reg.p_rs) + (PROD_W+1)'(m1_reg.p_ic);
        m2_next.base    = m1_reg.base;
        m2_next.wr      = W_W'(sum_r >>> 20);
        m2_next.wi      = W_W'(sum_i >>> 20);
        m2_next.act_old = ACT_W'(m1_reg.o_rr) - ACT_W'(m1_reg.o_ii);
    end

    always_comb
    begin
        logic signed [2*W_W-1:0] wr_e;
        logic signed [2*W_W-1:0] wi_e;
        wr_e = (2*W_W)'(m2_reg.wr);
        wi_e = (2*W_W)'(m2_reg.wi);
        m3_next.base    = m2_reg.base;
        m3_next.wr      = m2_reg.wr;
        m3_next.wi      = m2_reg.wi;
        m3_next.act_old = m2_reg.act_old;
        m3_next.sq_r    = SQ_W'(wr_e * wr_e);
        m3_next.sq_i    = SQ_W'(wi_e * wi_e);
    end

    // square root, one result bit per stage
    always_comb
    begin
        logic [SQ_W-1:0] test;
        sq_next[0].base    = m3_reg.base;
        sq_next[0].wr      = m3_reg.wr;
        sq_next[0].wi      = m3_reg.wi;
        sq_next[0].act_old = m3_reg.act_old;
        sq_next[0].rem     = m3_reg.sq_r + m3_reg.sq_i;
        sq_next[0].root    = '0;
        for (int i = 0; i < RT_W; i++)
        begin
            sq_next[i+1] = sq_reg[i];
            test = (SQ_W'(sq_reg[i].root) << (RT_W - i)) | (SQ_W'(1) << (2 * (RT_W - 1 - i)));
            if (sq_reg[i].rem >= test)
            begin
                sq_next[i+1].rem  = sq_reg[i].rem - test;
                sq_next[i+1].root = sq_reg[i].root | (RT_W'(1) << (RT_W - 1 - i));
            end
        end
    end

    // divider setup |w| * 2^14 + mag / 2, then one quotient bit per stage
    always_comb
    begin
        logic [RT_W-1:0] mr;
        logic [RT_W-1:0] mi;
        logic [RT_W-1:0] mag;
        logic [DR_W-1:0] dsr;
        mag = sq_reg[RT_W].root;
        mr  = RT_W'(sq_reg[RT_W].wr < 0 ? -sq_reg[RT_W].wr : sq_reg[RT_W].wr);
        mi  = RT_W'(sq_reg[RT_W].wi < 0 ? -sq_reg[RT_W].wi : sq_reg[RT_W].wi);
        dv_next[0].base    = sq_reg[RT_W].base;
        dv_next[0].act_old = sq_reg[RT_W].act_old;
        dv_next[0].neg_r   = sq_reg[RT_W].wr < 0;
        dv_next[0].neg_i   = sq_reg[RT_W].wi < 0;
        dv_next[0].zero    = mag == '0;
        dv_next[0].mag     = mag;
        dv_next[0].rem_r   = (DR_W'(mr) << 14) + DR_W'(mag >> 1);
        dv_next[0].rem_i   = (DR_W'(mi) << 14) + DR_W'(mag >> 1);
        dv_next[0].q_r     = '0;
        dv_next[0].q_i     = '0;
        for (int i = 0; i < QB; i++)
        begin
            dv_next[i+1] = dv_reg[i];
            dsr = DR_W'(dv_reg[i].mag) << (QB - 1 - i);
            if (dv_reg[i].rem_r >= dsr)
            begin
                dv_next[i+1].rem_r = dv_reg[i].rem_r - dsr;
                dv_next[i+1].q_r   = dv_reg[i].q_r | (QB'(1) << (QB - 1 - i));
            end
            if (dv_reg[i].rem_i >= dsr)
            begin
                dv_next[i+1].rem_i = dv_reg[i].rem_i - dsr;
                dv_next[i+1].q_i   = dv_reg[i].q_i | (QB'(1) << (QB - 1 - i));
            end
        end
    end

    always_comb
    begin
        logic [QB-1:0] qr;
        logic [QB-1:0] qi;
        qr = (dv_reg[QB].q_r > UNIT_Q14) ? UNIT_Q14 : dv_reg[QB].q_r;
        qi = (dv_reg[QB].q_i > UNIT_Q14) ? UNIT_Q14 : dv_reg[QB].q_i;
        f0_next.base    = dv_reg[QB].base;
        f0_next.act_old = dv_reg[QB].act_old;
        f0_next.zero    = dv_reg[QB].zero;
        f0_next.pr      = dv_reg[QB].neg_r ? -LINK_W'(qr) : LINK_W'(qr);
        f0_next.pi      = dv_reg[QB].neg_i ? -LINK_W'(qi) : LINK_W'(qi);
    end

    // action difference and scaling by beta
    always_comb
    begin
        a1_next.tl.ur   = f0_reg.base.ur;
        a1_next.tl.ui   = f0_reg.base.ui;
        a1_next.tl.rb   = f0_reg.base.rb;
        a1_next.tl.pr   = f0_reg.pr;
        a1_next.tl.pi   = f0_reg.pi;
        a1_next.tl.zero = f0_reg.zero;
        a1_next.act_old = f0_reg.act_old;
        a1_next.n_rr    = f0_reg.pr * f0_reg.base.sr;
        a1_next.n_ii    = f0_reg.pi * f0_reg.base.si;
    end

    always_comb
    begin
        a2_next.tl = a1_reg.tl;
        a2_next.d  = ACT_W'(a1_reg.n_rr) - ACT_W'(a1_reg.n_ii) - a1_reg.act_old;
    end

    always_comb
    begin
        a3_next.tl    = a2_reg.tl;
        a3_next.delta = a2_reg.d * $signed({1'b0, beta_reg});
    end

    // exp argument split into n * ln2 + r
    always_comb
    begin
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] nx;
        x  = X_W'(a3_reg.delta >>> 20);
        nx = -x;
        e0_next.tl  = a3_reg.tl;
        e0_next.pos = a3_reg.delta > 0;
        e0_next.sat = x <= EXP_FLOOR;
        e0_next.y   = (e0_next.pos | e0_next.sat) ? '0 : nx[Y_W-1:0];
        e0_next.yp  = '0;
    end

    always_comb
    begin
        e1_next    = e0_reg;
        e1_next.yp = e0_reg.y * LN2_RECIP;
    end

    // Taylor series, three stages per term: multiply, reciprocal, correct
    always_comb
    begin
        logic [N_W-1:0]        n;
        logic [Y_W-1:0]        r;
        logic [MF_W+R30_W-1:0] vm;
        logic [R30_W+2:0]      rm;
        logic [R30_W-1:0]      q;
        n = N_W'(e1_reg.yp >> 36);
        r = e1_reg.y - Y_W'(n) * Y_W'(LN2_Q16);
        hn_next[0].tl  = e1_reg.tl;
        hn_next[0].pos = e1_reg.pos;
        hn_next[0].sat = e1_reg.sat;
        hn_next[0].n   = n;
        hn_next[0].r30 = {r[R30_W-15:0], 14'd0};
        hn_next[0].t   = ONE_Q30;
        hn_next[0].hp  = '0;
        hn_next[0].v   = '0;
        hn_next[0].qe  = '0;
        for (int j = 0; j < HORNER_STEPS; j++)
        begin
            hn_next[3*j+1]    = hn_reg[3*j];
            hn_next[3*j+1].hp = HP_W'(hn_reg[3*j].r30) * HP_W'(hn_reg[3*j].t);

            hn_next[3*j+2]    = hn_reg[3*j+1];
            hn_next[3*j+2].v  = R30_W'(hn_reg[3*j+1].hp >> 30);
            vm = (MF_W+R30_W)'(hn_next[3*j+2].v) * (MF_W+R30_W)'(HORNER_MF[j]);
            hn_next[3*j+2].qe = R30_W'(vm >> 32);

            hn_next[3*j+3] = hn_reg[3*j+2];
            rm = (R30_W+3)'(hn_reg[3*j+2].v)
                 - (R30_W+3)'(hn_reg[3*j+2].qe) * (R30_W+3)'(HORNER_K[j]);
            q  = (rm >= (R30_W+3)'(HORNER_K[j])) ? hn_reg[3*j+2].qe + 1'b1
                                                  : hn_reg[3*j+2].qe;
            hn_next[3*j+3].t = ONE_Q30 - T_W'(q);
        end
    end

    // acceptance decision
    always_comb
    begin
        logic [RAND_W:0] e;
        logic            acc;
        e   = (RAND_W+1)'(hn_reg[HN_N].t >> 14) >> hn_reg[HN_N].n;
        acc = ~hn_reg[HN_N].tl.zero
              & (hn_reg[HN_N].pos | (~hn_reg[HN_N].sat & ({1'b0, hn_reg[HN_N].tl.rb} < e)));
        res.accepted = acc;
        res.new_re   = acc ? hn_reg[HN_N].tl.pr : hn_reg[HN_N].tl.ur;
        res.new_im   = acc ? hn_reg[HN_N].tl.pi : hn_reg[HN_N].tl.ui;
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= s0_next;
            for (int i = 0; i <= CORDIC_ITERS; i++)
            begin
                cr_reg[i] <= cr_next[i];
            end
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            for (int i = 0; i <= RT_W; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            for (int i = 0; i <= QB; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            f0_reg <= f0_next;
            a1_reg <= a1_next;
            a2_reg <= a2_next;
            a3_reg <= a3_next;
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            for (int i = 0; i <= HN_N; i++)
            begin
                hn_reg[i] <= hn_next[i];
            end
        end
    end

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (q1_valid_reg)
            begin
                q0_valid_reg <= 1'b1;
                q1_valid_reg <= push;
            end
            else
            begin
                q0_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (q0_valid_reg)
            begin
                q1_valid_reg <= 1'b1;
            end
            else
            begin
                q0_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (q1_valid_reg)
            begin
                q0_reg <= q1_reg;
                q1_reg <= res;
            end
            else
            begin
                q0_reg <= res;
            end
        end
        else if (push)
        begin
            if (q0_valid_reg)
            begin
                q1_reg <= res;
            end
            else
            begin
                q0_reg <= res;
            end
        end
    end

    assign link_out.valid    = q0_valid_reg;
    assign link_out.new_re   = q0_reg.new_re;
    assign link_out.new_im   = q0_reg.new_im;
    assign link_out.accepted = q0_reg.accepted;

    assign out_in_range = (link_out.new_re >= -16'sd16384) && (link_out.new_re <= 16'sd16384)
                          && (link_out.new_im >= -16'sd16384) && (link_out.new_im <= 16'sd16384);

`include "u1_metropolis_link_update_defines.svh"

    `U1ML_ASSERT_IMPLIES(a_buf_order, clk, rst_n, q1_valid_reg, q0_valid_reg, "second buffer entry without first")
    `U1ML_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(vld_reg), "pipeline moved while stalled")
    `U1ML_ASSERT_NEXT(a_buf_fill, clk, rst_n, push && !pop && q0_valid_reg, q1_valid_reg, "result dropped at buffer")
    `U1ML_ASSERT_IMPLIES(a_unit_range, clk, rst_n, link_out.valid && link_out.accepted, out_in_range, "accepted link out of unit range")

endmodule

`default_nettype wire

### tb/u1ml_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// U(1) Metropolis link update testbench - channel interfaces
// The channel interfaces come from the RTL interface file; this file adds only the link item package.
// ----------------------------------------------------------------------------
package u1ml_tb_pkg;
    import u1ml_pkg::*;

    typedef struct packed {
        logic signed [LINK_W-1:0]   link_re;
        logic signed [LINK_W-1:0]   link_im;
        logic signed [STAPLE_W-1:0] staple_re;
        logic signed [STAPLE_W-1:0] staple_im;
        logic [RAND_W-1:0]          rand_angle;
        logic [RAND_W-1:0]          rand_accept;
    } link_item_t;
endpackage

### tb/u1ml_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - result checker
// Watches the register, link and result channels, computes each updated
// link with its own fixed-point model and compares it with the block output.
// ----------------------------------------------------------------------------
module u1ml_checker
    import u1ml_pkg::*;
#(
    parameter int NUM_DIMS = NUM_DIMS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    u1ml_cfg_if.sink   cfg_mon,
    u1ml_in_if.sink    in_mon,
    u1ml_out_if.sink   out_mon,
    output int         errors,
    output int         pending
);
    localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic [BETA_W-1:0]  beta;
    logic [SCALE_W-1:0] scale;
    res_t               exp_buf [256];
    logic [7:0]         wr_ptr;
    logic [7:0]         rd_ptr;
    int                 fill;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint unit_comp(longint a, longint m);
        longint q;
        q = (((a < 0) ? -a : a) * 16384 + m / 2) / m;
        if (q > 16384)
            q = 16384;
        return (a < 0) ? -q : q;
    endfunction

    function automatic longint boltzmann_q16(longint d);
        longint x;
        longint y;
        longint n;
        longint r30;
        longint t;
        x = floor_shift(d, 20);
        if (x <= -(longint'(16) * 65536))
            return 0;
        y = -x;
        n = y / LN2_Q16;
        r30 = (y - n * LN2_Q16) << 14;
        t = longint'(1) << 30;
        for (int k = 7; k >= 1; k--)
            t = (longint'(1) << 30) - (((r30 * t) >>> 30) / k);
        return (t >>> 14) >>> n;
    endfunction

    function automatic res_t update_link(input logic signed [LINK_W-1:0] lr,
        input logic signed [LINK_W-1:0] li, input logic signed [STAPLE_W-1:0] sr_in,
        input logic signed [STAPLE_W-1:0] si_in, input logic [RAND_W-1:0] ra,
        input logic [RAND_W-1:0] rb);
        longint ur, ui, sr, si, lim, th, x, y, z, dx, dy, c, s, wr, wi, mag;
        longint pr, pi, d, delta;
        bit     flip;
        bit     acc;
        res_t   r;
        ur = lr;
        ui = li;
        sr = sr_in;
        si = si_in;
        lim = longint'(2 * (NUM_DIMS - 1)) * 16384;
        flip = 0;
        acc = 0;
        if (sr > lim) sr = lim;
        if (sr < -lim) sr = -lim;
        if (si > lim) si = lim;
        if (si < -lim) si = -lim;
        th = floor_shift(longint'(scale) * (2 * longint'(ra) - 65536), 13);
        if (th > 102944)
        begin
            th = th - 205887;
            flip = 1;
        end
        else if (th < -102944)
        begin
            th = th + 205887;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = th;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        wr = floor_shift(ur * c - ui * s, 20);
        wi = floor_shift(ur * s + ui * c, 20);
        mag = root_floor(wr * wr + wi * wi);
        r.new_re = lr;
        r.new_im = li;
        if (mag != 0)
        begin
            pr = unit_comp(wr, mag);
            pi = unit_comp(wi, mag);
            d = (pr * sr - pi * si) - (ur * sr - ui * si);
            delta = d * longint'(beta);
            acc = (delta > 0) ? 1'b1 : (longint'(rb) < boltzmann_q16(delta));
            if (acc)
            begin
                r.new_re = pr[LINK_W-1:0];
                r.new_im = pi[LINK_W-1:0];
            end
        end
        r.accepted = acc;
        return r;
    endfunction

    assign pending = fill;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta <= BETA_RST;
            scale <= SCALE_RST;
            errors <= 0;
            wr_ptr <= '0;
            rd_ptr <= '0;
            fill <= 0;
        end
        else
        begin
            res_t want;
            int   n_in;
            int   n_out;
            n_in = 0;
            n_out = 0;
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_BETA)
                    beta <= cfg_mon.data;
                else if (cfg_mon.index == REG_SCALE)
                    scale <= cfg_mon.data[SCALE_W-1:0];
            end
            if (in_mon.valid && in_mon.ready)
            begin
                exp_buf[wr_ptr] <= update_link(in_mon.link_re, in_mon.link_im,
                    in_mon.staple_re, in_mon.staple_im, in_mon.rand_angle,
                    in_mon.rand_accept);
                wr_ptr <= wr_ptr + 8'd1;
                n_in = 1;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (fill == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result re=%0d im=%0d acc=%0b",
                            out_mon.new_re, out_mon.new_im, out_mon.accepted);
                    errors <= errors + 1;
                end
                else
                begin
                    want = exp_buf[rd_ptr];
                    rd_ptr <= rd_ptr + 8'd1;
                    n_out = 1;
                    if (want.new_re !== out_mon.new_re || want.new_im !== out_mon.new_im
                        || want.accepted !== out_mon.accepted)
                    begin
                        if (errors < 10)
                            $display({"mismatch: expected re=%0d im=%0d acc=%0b, ",
                                "got re=%0d im=%0d acc=%0b"},
                                want.new_re, want.new_im, want.accepted,
                                out_mon.new_re, out_mon.new_im, out_mon.accepted);
                        errors <= errors + 1;
                    end
                end
            end
            fill <= fill + n_in - n_out;
        end
    end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// U(1) Metropolis link update - testbench top
// Drives directed and random link transactions under several register
// settings with bursty input and stalling output; the checker scores results.
// ----------------------------------------------------------------------------
module tb;
    import u1ml_pkg::*;
    import u1ml_tb_pkg::*;

    localparam int LATENCY   = 94;
    localparam int MAX_CYCLE = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   burst_left;
    int   gap_left;
    int   stall_mode = 0;
    longint cycle = 0;

    u1ml_cfg_if cfg ();
    u1ml_in_if  link_in ();
    u1ml_out_if link_out ();

    u1_metropolis_link_update DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg.sink),
        .link_in  (link_in.sink),
        .link_out (link_out.source)
    );

    u1ml_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_mon (cfg),
        .in_mon  (link_in),
        .out_mon (link_out),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: switch between free-flowing, random stalls and a periodic stall pattern
    always @(negedge clk)
    begin
        if ((cycle % 3000) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: link_out.ready <= 1'b1;
            1: link_out.ready <= ($urandom_range(0, 3) != 0);
            2: link_out.ready <= ($urandom_range(0, 1) != 0);
            default: link_out.ready <= ((cycle % 16) < 10);
        endcase
    end

    function automatic link_item_t rand_item();
        link_item_t it;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            it.link_re = LINK_W'($signed($urandom_range(0, 32768)) - 16384);
            it.link_im = LINK_W'($signed($urandom_range(0, 32768)) - 16384);
        end
        else
        begin
            it.link_re = LINK_W'($urandom);
            it.link_im = LINK_W'($urandom);
        end
        sel = $urandom_range(0, 9);
        if (sel < 8)
        begin
            it.staple_re = STAPLE_W'($signed($urandom_range(0, 196608)) - 98304);
            it.staple_im = STAPLE_W'($signed($urandom_range(0, 196608)) - 98304);
        end
        else
        begin
            it.staple_re = STAPLE_W'($urandom);
            it.staple_im = STAPLE_W'($urandom);
        end
        it.rand_angle = RAND_W'($urandom);
        it.rand_accept = RAND_W'($urandom);
        return it;
    endfunction

    task automatic send_link(input link_item_t it, input bit bursty);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                while (gap_left > 0)
                begin
                    link_in.valid <= 1'b0;
                    @(negedge clk);
                    gap_left--;
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        link_in.valid <= 1'b1;
        link_in.link_re <= it.link_re;
        link_in.link_im <= it.link_im;
        link_in.staple_re <= it.staple_re;
        link_in.staple_im <= it.staple_im;
        link_in.rand_angle <= it.rand_angle;
        link_in.rand_accept <= it.rand_accept;
        @(posedge clk);
        while (!link_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        link_in.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic directed();
        link_item_t it;
        for (int k = 0; k < 24; k++)
        begin
            it = rand_item();
            case (k)
                0: begin it.link_re = 16384; it.link_im = 0; end
                1: begin it.link_re = -16384; it.link_im = 0; end
                2: begin it.link_re = 0; it.link_im = 16384; end
                3: begin it.link_re = 0; it.link_im = -16384; end
                4: begin it.link_re = 0; it.link_im = 0; end
                5: begin it.link_re = 16'sh7fff; it.link_im = 16'sh8000; end
                6: begin it.staple_re = 98304; it.staple_im = -98304; end
                7: begin it.staple_re = 18'sh1ffff; it.staple_im = 18'sh20000; end
                8: it.rand_angle = 0;
                9: it.rand_angle = 16'hffff;
                10: it.rand_angle = 16'h8000;
                11: it.rand_accept = 0;
                12: it.rand_accept = 16'hffff;
                13: begin it.link_re = 16384; it.link_im = 0; it.staple_re = 98304;
                        it.staple_im = 0; it.rand_angle = 16'hffff;
                        it.rand_accept = 0; end
                14: begin it.link_re = 1; it.link_im = 0; end
                15: begin it.link_re = 11585; it.link_im = -11585; end
                default: ;
            endcase
            send_link(it, 1'b0);
        end
    endtask

    initial
    begin
        link_item_t it;
        logic [15:0] betas [6];
        logic [15:0] scales [6];
        betas = '{16'd256, 16'd0, 16'hffff, 16'd1, 16'd4096, 16'd300};
        scales = '{16'd4096, 16'd25736, 16'd0, 16'd1, 16'd25736, 16'd12000};
        burst_left = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_BETA;
        cfg.data = '0;
        link_in.valid = 1'b0;
        link_in.link_re = '0;
        link_in.link_im = '0;
        link_in.staple_re = '0;
        link_in.staple_im = '0;
        link_in.rand_angle = '0;
        link_in.rand_accept = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed();
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BETA, betas[ph]);
            write_reg(REG_SCALE, scales[ph]);
            write_reg(REG_SPARE, 16'h1234);
            if (ph == 1)
                directed();
            for (int k = 0; k < 170; k++)
            begin
                it = rand_item();
                send_link(it, 1'b1);
            end
            drain();
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### u1_metropolis_link_update.f
+incdir+rtl
rtl/u1ml_pkg.sv
rtl/u1ml_if.sv
rtl/u1_metropolis_link_update.sv
tb/u1ml_tb_if.sv
tb/u1ml_checker.sv
tb/tb.sv
